>>> hdl/qfs_pkg.sv
// ----------------------------------------------------------------------------
// qfs_pkg
// Shared types, codes and frame tables for the QUIC header and frame scanner.
// ----------------------------------------------------------------------------
package qfs_pkg;

    localparam int unsigned MAX_ID_LEN  = 20;
    localparam int unsigned MAX_PAYLOAD = 65535;

    // header phases
    localparam logic [3:0] HP_FIRST   = 4'd0;
    localparam logic [3:0] HP_SHORT   = 4'd1;
    localparam logic [3:0] HP_VERSION = 4'd2;
    localparam logic [3:0] HP_DCIDLEN = 4'd3;
    localparam logic [3:0] HP_DCID    = 4'd4;
    localparam logic [3:0] HP_SCIDLEN = 4'd5;
    localparam logic [3:0] HP_SCID    = 4'd6;
    localparam logic [3:0] HP_VN      = 4'd7;
    localparam logic [3:0] HP_TOKLEN  = 4'd8;
    localparam logic [3:0] HP_TOKEN   = 4'd9;
    localparam logic [3:0] HP_LENGTH  = 4'd10;
    localparam logic [3:0] HP_BODY    = 4'd11;
    localparam logic [3:0] HP_RETRY   = 4'd12;

    // frame phases
    localparam logic [3:0] FP_TYPE  = 4'd0;
    localparam logic [3:0] FP_FIELD = 4'd1;
    localparam logic [3:0] FP_GAP   = 4'd8;
    localparam logic [3:0] FP_RANGE = 4'd9;
    localparam logic [3:0] FP_SKIP  = 4'd10;
    localparam logic [3:0] FP_REST  = 4'd11;
    localparam logic [3:0] FP_CIDLEN = 4'd12;

    // what follows the varint fields of a frame
    localparam logic [2:0] TAIL_NONE     = 3'd0;
    localparam logic [2:0] TAIL_SKIPLAST = 3'd1;
    localparam logic [2:0] TAIL_REST     = 3'd2;
    localparam logic [2:0] TAIL_CID      = 3'd3;
    localparam logic [2:0] TAIL_SKIP8    = 3'd4;

    // packet kinds
    localparam logic [2:0] KIND_SHORT = 3'd0;
    localparam logic [2:0] KIND_VN    = 3'd1;
    localparam logic [2:0] KIND_INIT  = 3'd2;
    localparam logic [2:0] KIND_RETRY = 3'd5;

    // register indexes
    localparam logic REG_REGION_LIMIT = 1'b0;
    localparam logic REG_COUNT_LIMIT  = 1'b1;

    typedef struct packed {
        logic [2:0] count;
        logic [2:0] tail;
    } qfs_plan_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        qfs_plan_t  plan;
    } qfs_entry_t;

    typedef struct packed {
        logic [11:0] region_limit;
        logic [5:0]  count_limit;
    } qfs_cfg_t;

    typedef struct packed {
        logic [3:0]  phase;
        logic        load_skip;
        logic [63:0] skip;
    } qfs_tail_act_t;

    typedef struct packed {
        logic        parse_ok;
        logic        long_form;
        logic [2:0]  packet_kind;
        logic [31:0] version;
        logic [4:0]  dest_id_length;
        logic [4:0]  source_id_length;
        logic [13:0] offered_version_count;
        logic        frames_ok;
        logic        saw_ack;
        logic        saw_crypto;
        logic        saw_padding;
        logic        saw_stream;
    } qfs_result_t;

    function automatic qfs_plan_t frame_plan(input logic [7:0] t);
        qfs_plan_t p;
        p.count = 3'd1;
        p.tail  = TAIL_SKIPLAST;
        if (t[7:3] == 5'b00001) begin
            p.tail  = t[1] ? TAIL_SKIPLAST : TAIL_REST;
            p.count = 3'd1 + {2'd0, t[2]} + {2'd0, t[1]};
        end else begin
            case (t) inside
                8'h01, 8'h1E: begin p.count = 3'd0; p.tail = TAIL_NONE; end
                8'h02, 8'h03: begin p.count = 3'd4; p.tail = TAIL_NONE; end
                8'h04: begin p.count = 3'd3; p.tail = TAIL_NONE; end
                8'h05, 8'h11, 8'h15: begin p.count = 3'd2; p.tail = TAIL_NONE; end
                8'h06: begin p.count = 3'd2; p.tail = TAIL_SKIPLAST; end
                8'h07: begin p.count = 3'd1; p.tail = TAIL_SKIPLAST; end
                8'h10, 8'h12, 8'h13, 8'h14, 8'h16, 8'h17, 8'h19:
                    begin p.count = 3'd1; p.tail = TAIL_NONE; end
                8'h18: begin p.count = 3'd2; p.tail = TAIL_CID; end
                8'h1A, 8'h1B: begin p.count = 3'd0; p.tail = TAIL_SKIP8; end
                8'h1C: begin p.count = 3'd3; p.tail = TAIL_SKIPLAST; end
                8'h1D: begin p.count = 3'd2; p.tail = TAIL_SKIPLAST; end
                default: begin p.count = 3'd1; p.tail = TAIL_SKIPLAST; end
            endcase
        end
        return p;
    endfunction

    function automatic qfs_tail_act_t apply_tail(input logic [2:0] tail,
                                                 input logic [63:0] v);
        qfs_tail_act_t a;
        a.phase     = FP_TYPE;
        a.load_skip = 1'b0;
        a.skip      = v;
        case (tail)
            TAIL_SKIPLAST: begin
                a.load_skip = 1'b1;
                a.phase     = (v == 64'd0) ? FP_TYPE : FP_SKIP;
            end
            TAIL_REST: a.phase = FP_REST;
            TAIL_CID:  a.phase = FP_CIDLEN;
            TAIL_SKIP8: begin
                a.load_skip = 1'b1;
                a.skip      = 64'd8;
                a.phase     = FP_SKIP;
            end
            default: a.phase = FP_TYPE;
        endcase
        return a;
    endfunction

endpackage

>>> hdl/qfs_in_if.sv
// ----------------------------------------------------------------------------
// qfs_in_if
// Payload byte channel: one byte per word, last flag marks the end.
// ----------------------------------------------------------------------------
interface qfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> hdl/qfs_out_if.sv
// ----------------------------------------------------------------------------
// qfs_out_if
// Packet summary channel: one summary word per payload.
// ----------------------------------------------------------------------------
interface qfs_out_if;
    logic        valid;
    logic        ready;
    logic        parse_ok;
    logic        long_form;
    logic [2:0]  packet_kind;
    logic [31:0] version;
    logic [4:0]  dest_id_length;
    logic [4:0]  source_id_length;
    logic [13:0] offered_version_count;
    logic        frames_ok;
    logic        saw_ack;
    logic        saw_crypto;
    logic        saw_padding;
    logic        saw_stream;

    modport source (output valid, output parse_ok, output long_form,
                    output packet_kind, output version, output dest_id_length,
                    output source_id_length, output offered_version_count,
                    output frames_ok, output saw_ack, output saw_crypto,
                    output saw_padding, output saw_stream, input ready);
    modport sink (input valid, input parse_ok, input long_form,
                  input packet_kind, input version, input dest_id_length,
                  input source_id_length, input offered_version_count,
                  input frames_ok, input saw_ack, input saw_crypto,
                  input saw_padding, input saw_stream, output ready);
endinterface

>>> hdl/qfs_front.sv
// ----------------------------------------------------------------------------
// qfs_front
// Accepts payload bytes, tags each with its frame-type plan, and queues them.
// ----------------------------------------------------------------------------
module qfs_front
    import qfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    qfs_in_if.sink     in_ch,
    output logic       head_valid,
    output qfs_entry_t head,
    input  logic       pop
);

    qfs_entry_t q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    qfs_entry_t new_entry;

    assign in_ch.ready = (count_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign head_valid  = (count_reg != 2'd0);
    assign head        = q_reg[rd_ptr_reg];

    always_comb
    begin
        new_entry.data = in_ch.data_byte;
        new_entry.last = in_ch.last_byte;
        new_entry.plan = frame_plan(in_ch.data_byte);
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

>>> hdl/qfs_back.sv
// ----------------------------------------------------------------------------
// qfs_back
// Walks header and frames a byte a cycle unless stalled; registers the summary.
// ----------------------------------------------------------------------------
module qfs_back
    import qfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  qfs_cfg_t   cfg,
    input  logic       head_valid,
    input  qfs_entry_t head,
    output logic       pop,
    qfs_out_if.source  out_ch
);

    logic [16:0] pos_reg, pos_next;
    logic [7:0]  fhb_reg, fhb_next;
    logic [3:0]  hp_reg, hp_next;
    logic [31:0] ver_reg, ver_next;
    logic [4:0]  dlen_reg, dlen_next;
    logic [4:0]  slen_reg, slen_next;
    logic [63:0] acc_reg, acc_next;
    logic [2:0]  vleft_reg, vleft_next;
    logic [63:0] skip_reg, skip_next;
    logic [16:0] rstart_reg, rstart_next;
    logic [16:0] rend_reg, rend_next;
    logic [3:0]  fp_reg, fp_next;
    logic [7:0]  ftype_reg, ftype_next;
    logic [63:0] ackleft_reg, ackleft_next;
    logic [5:0]  fcnt_reg, fcnt_next;
    logic [3:0]  flags_reg, flags_next;
    logic        pfail_reg, pfail_next;
    logic        ffail_reg, ffail_next;

    logic        out_valid_reg;
    qfs_result_t out_reg;
    qfs_result_t result;

    logic [7:0]  b;
    logic [63:0] vf_acc;
    logic [2:0]  vf_left;
    logic        vf_done;
    logic [16:0] pos_p1;
    logic [2:0]  pn;
    logic [15:0] len16;
    logic        len_bad;
    logic [15:0] body_size;
    logic        ids_fail;
    logic [3:0]  ids_phase;
    logic [63:0] skip_dec;
    logic [63:0] ack_dec;
    logic [3:0]  fk;
    logic        is_ack;
    logic [3:0]  ack_tail_phase;
    qfs_plan_t   reg_plan;
    qfs_tail_act_t ta;
    logic        in_region;
    logic [16:0] diff;
    logic        ok;
    logic        fok;
    logic [2:0]  kind;
    logic [13:0] vwords;

    assign b   = head.data;
    assign pop = head_valid && (!head.last || !out_valid_reg || out_ch.ready);

    always_comb
    begin
        if (vleft_reg == 3'd0)
        begin
            vf_acc = {58'd0, b[5:0]};
            case (b[7:6])
                2'd0: vf_left = 3'd0;
                2'd1: vf_left = 3'd1;
                2'd2: vf_left = 3'd3;
                default: vf_left = 3'd7;
            endcase
        end
        else
        begin
            vf_acc  = {acc_reg[55:0], b};
            vf_left = vleft_reg - 3'd1;
        end
        vf_done = (vf_left == 3'd0);
    end

    always_comb
    begin
        pos_p1    = pos_reg + 17'd1;
        pn        = {1'b0, fhb_reg[1:0]} + 3'd1;
        len16     = vf_acc[15:0];
        len_bad   = (|vf_acc[63:16]) || (len16 < {13'd0, pn});
        body_size = len16 - {13'd0, pn};
        ids_fail  = (ver_reg != 32'd0) && !fhb_reg[6];
        if (ver_reg == 32'd0)
        begin
            ids_phase = HP_VN;
        end
        else if (fhb_reg[5:4] == 2'd0)
        begin
            ids_phase = HP_TOKLEN;
        end
        else if (fhb_reg[5:4] == 2'd3)
        begin
            ids_phase = HP_RETRY;
        end
        else
        begin
            ids_phase = HP_LENGTH;
        end
        skip_dec       = skip_reg - 64'd1;
        ack_dec        = ackleft_reg - 64'd1;
        fk             = fp_reg - FP_FIELD;
        is_ack         = (ftype_reg == 8'h02) || (ftype_reg == 8'h03);
        ack_tail_phase = (ftype_reg == 8'h03) ? (FP_FIELD + 4'd4) : FP_TYPE;
        reg_plan       = frame_plan(ftype_reg);
        in_region      = (pos_reg >= rstart_reg) && (pos_reg < rend_reg) && !ffail_reg;
    end

    always_comb
    begin
        pos_next     = (pos_reg <= 17'(MAX_PAYLOAD)) ? pos_p1 : pos_reg;
        fhb_next     = fhb_reg;
        hp_next      = hp_reg;
        ver_next     = ver_reg;
        dlen_next    = dlen_reg;
        slen_next    = slen_reg;
        acc_next     = acc_reg;
        vleft_next   = vleft_reg;
        skip_next    = skip_reg;
        rstart_next  = rstart_reg;
        rend_next    = rend_reg;
        fp_next      = fp_reg;
        ftype_next   = ftype_reg;
        ackleft_next = ackleft_reg;
        fcnt_next    = fcnt_reg;
        flags_next   = flags_reg;
        ffail_next   = ffail_reg;
        pfail_next   = pfail_reg || (pos_reg >= 17'(MAX_PAYLOAD));
        ta           = apply_tail(TAIL_NONE, 64'd0);

        if (!pfail_next)
        begin
            unique case (hp_reg)
                HP_FIRST:
                begin
                    fhb_next = b;
                    if (b[7])
                    begin
                        hp_next = HP_VERSION;
                    end
                    else if (!b[6])
                    begin
                        pfail_next = 1'b1;
                    end
                    else
                    begin
                        hp_next = HP_SHORT;
                    end
                end
                HP_VERSION:
                begin
                    ver_next = {ver_reg[23:0], b};
                    if (pos_reg == 17'd4)
                    begin
                        hp_next = HP_DCIDLEN;
                    end
                end
                HP_DCIDLEN:
                begin
                    if (b > 8'(MAX_ID_LEN))
                    begin
                        pfail_next = 1'b1;
                    end
                    else
                    begin
                        dlen_next = b[4:0];
                        skip_next = {56'd0, b};
                        hp_next   = (b == 8'd0) ? HP_SCIDLEN : HP_DCID;
                    end
                end
                HP_DCID:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 64'd0)
                    begin
                        hp_next = HP_SCIDLEN;
                    end
                end
                HP_SCIDLEN:
                begin
                    if (b > 8'(MAX_ID_LEN))
                    begin
                        pfail_next = 1'b1;
                    end
                    else
                    begin
                        slen_next = b[4:0];
                        skip_next = {56'd0, b};
                        if (b == 8'd0)
                        begin
                            rstart_next = pos_p1;
                            if (ids_fail)
                            begin
                                pfail_next = 1'b1;
                            end
                            else
                            begin
                                hp_next = ids_phase;
                            end
                        end
                        else
                        begin
                            hp_next = HP_SCID;
                        end
                    end
                end
                HP_SCID:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 64'd0)
                    begin
                        rstart_next = pos_p1;
                        if (ids_fail)
                        begin
                            pfail_next = 1'b1;
                        end
                        else
                        begin
                            hp_next = ids_phase;
                        end
                    end
                end
                HP_TOKLEN:
                begin
                    acc_next   = vf_acc;
                    vleft_next = vf_left;
                    if (vf_done)
                    begin
                        skip_next = vf_acc;
                        hp_next   = (vf_acc == 64'd0) ? HP_LENGTH : HP_TOKEN;
                    end
                end
                HP_TOKEN:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 64'd0)
                    begin
                        hp_next = HP_LENGTH;
                    end
                end
                HP_LENGTH:
                begin
                    acc_next   = vf_acc;
                    vleft_next = vf_left;
                    if (vf_done)
                    begin
                        if (len_bad)
                        begin
                            pfail_next = 1'b1;
                        end
                        else
                        begin
                            rstart_next = pos_p1 + {14'd0, pn};
                            rend_next   = pos_p1 + {1'b0, len16};
                            if ((body_size == 16'd0) ||
                                (body_size > {4'd0, cfg.region_limit}))
                            begin
                                ffail_next = 1'b1;
                            end
                            hp_next = HP_BODY;
                        end
                    end
                end
                HP_BODY:
                begin
                    if (in_region)
                    begin
                        case (fp_reg)
                            FP_TYPE:
                            begin
                                if (fcnt_reg >= cfg.count_limit)
                                begin
                                    ffail_next = 1'b1;
                                end
                                else
                                begin
                                    fcnt_next  = fcnt_reg + 6'd1;
                                    ftype_next = b;
                                    if (b == 8'h00)
                                    begin
                                        flags_next[2] = 1'b1;
                                    end
                                    else
                                    begin
                                        if ((b == 8'h02) || (b == 8'h03))
                                        begin
                                            flags_next[0] = 1'b1;
                                        end
                                        if (b == 8'h06)
                                        begin
                                            flags_next[1] = 1'b1;
                                        end
                                        if (b[7:3] == 5'b00001)
                                        begin
                                            flags_next[3] = 1'b1;
                                        end
                                        if (head.plan.count != 3'd0)
                                        begin
                                            fp_next = FP_FIELD;
                                        end
                                        else
                                        begin
                                            ta      = apply_tail(head.plan.tail, 64'd0);
                                            fp_next = ta.phase;
                                            if (ta.load_skip)
                                            begin
                                                skip_next = ta.skip;
                                            end
                                        end
                                    end
                                end
                            end
                            FP_SKIP:
                            begin
                                skip_next = skip_dec;
                                if (skip_dec == 64'd0)
                                begin
                                    fp_next = FP_TYPE;
                                end
                            end
                            FP_REST:
                            begin
                                fp_next = FP_REST;
                            end
                            FP_CIDLEN:
                            begin
                                skip_next = {56'd0, b} + 64'd16;
                                fp_next   = FP_SKIP;
                            end
                            default:
                            begin
                                acc_next   = vf_acc;
                                vleft_next = vf_left;
                                if (vf_done)
                                begin
                                    if (fp_reg == FP_GAP)
                                    begin
                                        fp_next = FP_RANGE;
                                    end
                                    else if (fp_reg == FP_RANGE)
                                    begin
                                        ackleft_next = ack_dec;
                                        fp_next = (ack_dec != 64'd0) ? FP_GAP : ack_tail_phase;
                                    end
                                    else if (is_ack)
                                    begin
                                        if (fk == 4'd2)
                                        begin
                                            ackleft_next = vf_acc;
                                        end
                                        if (fk == 4'd3)
                                        begin
                                            fp_next = (ackleft_reg != 64'd0) ?
                                                      FP_GAP : ack_tail_phase;
                                        end
                                        else if (fk == 4'd6)
                                        begin
                                            fp_next = FP_TYPE;
                                        end
                                        else
                                        begin
                                            fp_next = fp_reg + 4'd1;
                                        end
                                    end
                                    else if ((fk + 4'd1) < {1'b0, reg_plan.count})
                                    begin
                                        fp_next = fp_reg + 4'd1;
                                    end
                                    else
                                    begin
                                        ta      = apply_tail(reg_plan.tail, vf_acc);
                                        fp_next = ta.phase;
                                        if (ta.load_skip)
                                        begin
                                            skip_next = ta.skip;
                                        end
                                    end
                                end
                            end
                        endcase
                    end
                end
                default:
                begin
                    hp_next = hp_reg;
                end
            endcase
        end
    end

    // summary from the state left after this byte
    always_comb
    begin
        diff   = pos_p1 - rstart_next;
        ok     = 1'b0;
        fok    = 1'b0;
        kind   = KIND_SHORT;
        vwords = 14'd0;
        case (hp_next)
            HP_SHORT: ok = (pos_p1 >= 17'd4);
            HP_VN:
            begin
                ok     = 1'b1;
                kind   = KIND_VN;
                vwords = diff[15:2];
            end
            HP_RETRY:
            begin
                ok   = (diff >= 17'd16);
                kind = KIND_RETRY;
            end
            HP_BODY:
            begin
                ok   = (pos_p1 >= rend_next);
                kind = KIND_INIT + {1'b0, fhb_next[5:4]};
                fok  = !ffail_next && ((fp_next == FP_TYPE) || (fp_next == FP_REST));
            end
            default: ok = 1'b0;
        endcase
        if (pfail_next)
        begin
            ok = 1'b0;
        end
        result = '0;
        if (ok)
        begin
            result.parse_ok              = 1'b1;
            result.long_form             = fhb_next[7];
            result.packet_kind           = kind;
            result.version               = fhb_next[7] ? ver_next : 32'd0;
            result.dest_id_length        = fhb_next[7] ? dlen_next : 5'd0;
            result.source_id_length      = fhb_next[7] ? slen_next : 5'd0;
            result.offered_version_count = vwords;
            if (fok)
            begin
                result.frames_ok   = 1'b1;
                result.saw_ack     = flags_next[0];
                result.saw_crypto  = flags_next[1];
                result.saw_padding = flags_next[2];
                result.saw_stream  = flags_next[3];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            fhb_reg     <= '0;
            hp_reg      <= HP_FIRST;
            ver_reg     <= '0;
            dlen_reg    <= '0;
            slen_reg    <= '0;
            acc_reg     <= '0;
            vleft_reg   <= '0;
            skip_reg    <= '0;
            rstart_reg  <= '0;
            rend_reg    <= '0;
            fp_reg      <= FP_TYPE;
            ftype_reg   <= '0;
            ackleft_reg <= '0;
            fcnt_reg    <= '0;
            flags_reg   <= '0;
            pfail_reg   <= 1'b0;
            ffail_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && head.last)
            begin
                // end of payload: clear for the next one
                pos_reg     <= '0;
                fhb_reg     <= '0;
                hp_reg      <= HP_FIRST;
                ver_reg     <= '0;
                dlen_reg    <= '0;
                slen_reg    <= '0;
                acc_reg     <= '0;
                vleft_reg   <= '0;
                skip_reg    <= '0;
                rstart_reg  <= '0;
                rend_reg    <= '0;
                fp_reg      <= FP_TYPE;
                ftype_reg   <= '0;
                ackleft_reg <= '0;
                fcnt_reg    <= '0;
                flags_reg   <= '0;
                pfail_reg   <= 1'b0;
                ffail_reg   <= 1'b0;
            end
            else if (pop)
            begin
                pos_reg     <= pos_next;
                fhb_reg     <= fhb_next;
                hp_reg      <= hp_next;
                ver_reg     <= ver_next;
                dlen_reg    <= dlen_next;
                slen_reg    <= slen_next;
                acc_reg     <= acc_next;
                vleft_reg   <= vleft_next;
                skip_reg    <= skip_next;
                rstart_reg  <= rstart_next;
                rend_reg    <= rend_next;
                fp_reg      <= fp_next;
                ftype_reg   <= ftype_next;
                ackleft_reg <= ackleft_next;
                fcnt_reg    <= fcnt_next;
                flags_reg   <= flags_next;
                pfail_reg   <= pfail_next;
                ffail_reg   <= ffail_next;
            end

            if (pop && head.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
        begin
            out_reg <= result;
        end
    end

    assign out_ch.valid                 = out_valid_reg;
    assign out_ch.parse_ok              = out_reg.parse_ok;
    assign out_ch.long_form             = out_reg.long_form;
    assign out_ch.packet_kind           = out_reg.packet_kind;
    assign out_ch.version               = out_reg.version;
    assign out_ch.dest_id_length        = out_reg.dest_id_length;
    assign out_ch.source_id_length      = out_reg.source_id_length;
    assign out_ch.offered_version_count = out_reg.offered_version_count;
    assign out_ch.frames_ok             = out_reg.frames_ok;
    assign out_ch.saw_ack               = out_reg.saw_ack;
    assign out_ch.saw_crypto            = out_reg.saw_crypto;
    assign out_ch.saw_padding           = out_reg.saw_padding;
    assign out_ch.saw_stream            = out_reg.saw_stream;

endmodule

>>> hdl/quic_packet_header_frame_scan_top.sv
// Summary path: the last payload byte passes the queue stage, then the
//   parser's output register, before its summary word is valid.
// Throughput: one payload byte per cycle, except that a last byte waits while
//   the previous summary is untaken; a two-entry queue absorbs output stalls.
// Reset: rst_n clears all parse state asynchronously and sets the region
//   limit to 512 and the frame count limit to 32.
// ----------------------------------------------------------------------------
// quic_packet_header_frame_scan_top
// QUIC packet header checker and frame scanner with an APB register port.
// ----------------------------------------------------------------------------
module quic_packet_header_frame_scan_top
    import qfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    qfs_in_if.sink      in_ch,
    qfs_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [11:0] region_limit_reg;
    logic [5:0]  count_limit_reg;
    logic        cfg_write;
    qfs_cfg_t    cfg;
    logic        head_valid;
    qfs_entry_t  head;
    logic        pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg.region_limit = region_limit_reg;
    assign cfg.count_limit  = count_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_limit_reg <= 12'd512;
            count_limit_reg  <= 6'd32;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_REGION_LIMIT)
            begin
                region_limit_reg <= pwdata[11:0];
            end
            else
            begin
                count_limit_reg <= pwdata[5:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_COUNT_LIMIT)
        begin
            prdata = {26'd0, count_limit_reg};
        end
        else
        begin
            prdata = {20'd0, region_limit_reg};
        end
    end

    qfs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    qfs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

>>> hdl/qfs_checker.sv
// ----------------------------------------------------------------------------
// qfs_checker
// Port-level checks on the summary channel, bound to the top level.
// ----------------------------------------------------------------------------
module qfs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic        parse_ok,
    input logic        long_form,
    input logic [2:0]  packet_kind,
    input logic [31:0] version,
    input logic [4:0]  dest_id_length,
    input logic [4:0]  source_id_length,
    input logic [13:0] offered_version_count,
    input logic        frames_ok,
    input logic [3:0]  saw
);

    // hold a pending summary until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("summary dropped before it was taken");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !parse_ok |-> !long_form && packet_kind == 3'd0 &&
            version == 32'd0 && dest_id_length == 5'd0 &&
            source_id_length == 5'd0 && offered_version_count == 14'd0 &&
            !frames_ok && saw == 4'd0)
        else $error("failed packet carries nonzero fields");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !frames_ok |-> saw == 4'd0)
        else $error("frame flags set without a clean frame region");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        valid && parse_ok |-> (long_form == (packet_kind != 3'd0)) &&
            (!frames_ok || (packet_kind != 3'd0 && packet_kind != 3'd1 &&
                            packet_kind != 3'd5)))
        else $error("packet kind inconsistent with header form");

    a_cid: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> dest_id_length <= 5'd20 && source_id_length <= 5'd20)
        else $error("connection ID length above limit");

endmodule

bind quic_packet_header_frame_scan_top qfs_checker u_qfs_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .valid                 (out_ch.valid),
    .ready                 (out_ch.ready),
    .parse_ok              (out_ch.parse_ok),
    .long_form             (out_ch.long_form),
    .packet_kind           (out_ch.packet_kind),
    .version               (out_ch.version),
    .dest_id_length        (out_ch.dest_id_length),
    .source_id_length      (out_ch.source_id_length),
    .offered_version_count (out_ch.offered_version_count),
    .frames_ok             (out_ch.frames_ok),
    .saw                   ({out_ch.saw_stream, out_ch.saw_padding,
                             out_ch.saw_crypto, out_ch.saw_ack})
);
